@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers used by the core RTL. All checks sample on clk
// and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MPPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MPPR_ASSERT_IMP(label, ante, cons, msg)
`define MPPR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/mppr_pkg.sv @@
// ----------------------------------------------------------------------------
// mppr_pkg
// Shared widths, codes and types of the midpoint parabola rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mppr_pkg;

  // fixed field widths
  localparam int FOCAL_W  = 10;
  localparam int LIMIT_W  = 11;
  localparam int COLOUR_W = 8;
  localparam int WALK_X_W = 24;
  localparam int WALK_Y_W = 12;
  localparam int DEC_W    = 24;

  // parameter defaults
  localparam int COORD_WIDTH_DEF = 12;
  localparam int OUT_WIDTH_DEF   = 16;

  // walker x stops here instead of wrapping
  localparam logic [WALK_X_W-1:0] WALK_X_MAX = {WALK_X_W{1'b1}};

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // walker state
  typedef struct packed {
    logic                     busy;
    logic                     region_two;
    logic [WALK_X_W-1:0]      walk_x;
    logic [WALK_Y_W-1:0]      walk_y;
    logic signed [DEC_W-1:0]  decision;
  } walk_t;

  // curve shape latched on start
  typedef struct packed {
    logic [FOCAL_W-1:0] focal;
    logic               vertical;
    logic [LIMIT_W-1:0] limit;
  } curve_t;

  // result flags
  typedef struct packed {
    logic point_valid;
    logic last;
  } flags_t;

endpackage

@@ rtl/core/midpoint_parabola_raster_core.sv @@
// ----------------------------------------------------------------------------
// midpoint_parabola_raster_core
// Midpoint rasterizer for y^2 = 4ax emitting mirrored point pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the command (0 start, 1 step), in_tdata
//   carries the curve parameters. A start item latches vertex, focal distance,
//   orientation, limit and colour and produces no output item. Each step item
//   produces exactly one output item: a point pair, or an empty item with
//   tuser low and tlast high when no curve is active or the curve is done.
//   Output stream: out_tuser is the point-valid flag, out_tlast marks the
//   final pair of a curve.
//   Path: an accepted item sits in the input register, and a step's result
//   is registered in the output register once the output slot is free.
//   Throughput: one item per cycle unless the output stalls; the step is a
//   few adds and compares on registered walker state, so steps issue back to back.
//   Stalls: with out_tready low the output register holds its item; the input
//   register keeps accepting start items and holds a step until the output
//   frees up, so in_tready drops only when both are occupied.
//   Reset (rst_n low, synchronous): both registers empty, walker idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midpoint_parabola_raster_core #(
  parameter int COORD_WIDTH = mppr_pkg::COORD_WIDTH_DEF,
  parameter int OUT_WIDTH   = mppr_pkg::OUT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // centre_x, centre_y, focal_a, vertical, x_limit, y_limit,
  // red_in, green_in, blue_in (lowest bits first), zero pad to bytes
  input  logic [((2*COORD_WIDTH + mppr_pkg::FOCAL_W + 1 + 2*mppr_pkg::LIMIT_W
                 + 3*mppr_pkg::COLOUR_W + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                      in_tuser,   // cmd
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // first_px, first_py, second_px, second_py, red_out, green_out, blue_out
  // (lowest bits first), zero pad to bytes
  output logic [((4*OUT_WIDTH + 3*mppr_pkg::COLOUR_W + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                      out_tuser,  // point_valid
  output logic                      out_tlast   // last
);

  localparam int CW  = COORD_WIDTH;
  localparam int FW  = mppr_pkg::FOCAL_W;
  localparam int LW  = mppr_pkg::LIMIT_W;
  localparam int KW  = mppr_pkg::COLOUR_W;
  localparam int DW  = mppr_pkg::DEC_W;

  localparam int IN_RAW_W   = 2*CW + FW + 1 + 2*LW + 3*KW;
  localparam int OUT_RAW_W  = 4*OUT_WIDTH + 3*KW;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CX_LSB = 0;
  localparam int CY_LSB = CX_LSB + CW;
  localparam int FA_LSB = CY_LSB + CW;
  localparam int VT_LSB = FA_LSB + FW;
  localparam int XL_LSB = VT_LSB + 1;
  localparam int YL_LSB = XL_LSB + LW;
  localparam int R_LSB  = YL_LSB + LW;
  localparam int G_LSB  = R_LSB + KW;
  localparam int B_LSB  = G_LSB + KW;

  // input register
  logic                  s1_v_r;
  mppr_pkg::cmd_t        s1_cmd_r;
  logic [IN_RAW_W-1:0]   s1_data_r;
  logic                  s1_go;

  // latched curve
  mppr_pkg::walk_t                walk_r;
  mppr_pkg::walk_t                walk_nxt;
  mppr_pkg::curve_t               curve_r;
  logic signed [CW-1:0]           held_cx_r;
  logic signed [CW-1:0]           held_cy_r;
  logic [KW-1:0]                  red_r;
  logic [KW-1:0]                  green_r;
  logic [KW-1:0]                  blue_r;

  // output register
  logic                  out_v_r;
  logic                  out_v_nxt;
  logic [OUT_RAW_W-1:0]  out_data_r;
  mppr_pkg::flags_t      out_flags_r;

  // step results
  mppr_pkg::walk_t               step_walk;
  mppr_pkg::flags_t              step_flags;
  logic signed [OUT_WIDTH-1:0]   step_fpx;
  logic signed [OUT_WIDTH-1:0]   step_fpy;
  logic signed [OUT_WIDTH-1:0]   step_spx;
  logic signed [OUT_WIDTH-1:0]   step_spy;
  logic [3*KW-1:0]               step_rgb;

  // start decode
  logic [FW-1:0]         s1_focal;
  logic                  s1_vertical;
  mppr_pkg::walk_t       start_walk;

  // handshake: a start never needs the output, a step needs a free slot
  always_comb begin
    s1_go     = s1_v_r && ((s1_cmd_r == mppr_pkg::CMD_START) || !out_v_r || out_tready);
    in_tready = !s1_v_r || s1_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= mppr_pkg::cmd_t'(in_tuser);
      s1_data_r <= in_tdata[IN_RAW_W-1:0];
    end
  end

  // walker after a start: x = y = 0, decision 1 - 2a
  always_comb begin
    s1_focal               = s1_data_r[FA_LSB +: FW];
    s1_vertical            = s1_data_r[VT_LSB];
    start_walk.busy        = 1'b1;
    start_walk.region_two  = 1'b0;
    start_walk.walk_x      = '0;
    start_walk.walk_y      = '0;
    start_walk.decision    = $signed(DW'(1)) - $signed({{(DW-FW-1){1'b0}}, s1_focal, 1'b0});
  end

  mppr_step #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_WIDTH   (OUT_WIDTH)
  ) u_step (
    .walk_i      (walk_r),
    .curve_i     (curve_r),
    .centre_x_i  (held_cx_r),
    .centre_y_i  (held_cy_r),
    .walk_o      (step_walk),
    .flags_o     (step_flags),
    .first_px_o  (step_fpx),
    .first_py_o  (step_fpy),
    .second_px_o (step_spx),
    .second_py_o (step_spy)
  );

  always_comb begin
    walk_nxt = walk_r;
    if (s1_go) begin
      walk_nxt = (s1_cmd_r == mppr_pkg::CMD_START) ? start_walk : step_walk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '0;
    end else begin
      walk_r <= walk_nxt;
    end
  end

  // curve parameters latched on start
  always_ff @(posedge clk) begin
    if (s1_go && (s1_cmd_r == mppr_pkg::CMD_START)) begin
      held_cx_r        <= $signed(s1_data_r[CX_LSB +: CW]);
      held_cy_r        <= $signed(s1_data_r[CY_LSB +: CW]);
      curve_r.focal    <= s1_focal;
      curve_r.vertical <= s1_vertical;
      curve_r.limit    <= s1_vertical ? s1_data_r[XL_LSB +: LW] : s1_data_r[YL_LSB +: LW];
      red_r            <= s1_data_r[R_LSB +: KW];
      green_r          <= s1_data_r[G_LSB +: KW];
      blue_r           <= s1_data_r[B_LSB +: KW];
    end
  end

  // colour only rides along with a real pair
  assign step_rgb = step_flags.point_valid ? {blue_r, green_r, red_r} : '0;

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && (s1_cmd_r == mppr_pkg::CMD_STEP)) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_cmd_r == mppr_pkg::CMD_STEP)) begin
      out_data_r  <= {step_rgb, step_spy, step_spx, step_fpy, step_fpx};
      out_flags_r <= step_flags;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, out_data_r};
  assign out_tuser  = out_flags_r.point_valid;
  assign out_tlast  = out_flags_r.last;

  // checks
  `MPPR_ASSERT_IMP(a_region_one_bound, walk_r.busy && !walk_r.region_two,
    walk_r.walk_y <= {1'b0, curve_r.focal, 1'b0}, "region one walked past 2a")
  `MPPR_ASSERT_IMP(a_region_two_floor, walk_r.region_two,
    walk_r.walk_y >= {1'b0, curve_r.focal, 1'b0}, "region two below 2a")
  `MPPR_ASSERT_NXT(a_step_result, s1_go && (s1_cmd_r == mppr_pkg::CMD_STEP),
    out_tvalid, "step item produced no result")
  `MPPR_ASSERT_IMP(a_empty_is_last, out_tvalid && !out_tuser,
    out_tlast, "empty result not marked last")

endmodule

@@ rtl/core/mppr_step.sv @@
// ----------------------------------------------------------------------------
// mppr_step
// One midpoint step of the parabola walker: next walker state, the mirrored
// point pair with saturation, and the valid/last flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mppr_step #(
  parameter int COORD_WIDTH = mppr_pkg::COORD_WIDTH_DEF,
  parameter int OUT_WIDTH   = mppr_pkg::OUT_WIDTH_DEF
) (
  input  mppr_pkg::walk_t                walk_i,
  input  mppr_pkg::curve_t               curve_i,
  input  logic signed [COORD_WIDTH-1:0]  centre_x_i,
  input  logic signed [COORD_WIDTH-1:0]  centre_y_i,
  output mppr_pkg::walk_t                walk_o,
  output mppr_pkg::flags_t               flags_o,
  output logic signed [OUT_WIDTH-1:0]    first_px_o,
  output logic signed [OUT_WIDTH-1:0]    first_py_o,
  output logic signed [OUT_WIDTH-1:0]    second_px_o,
  output logic signed [OUT_WIDTH-1:0]    second_py_o
);

  localparam int WX = mppr_pkg::WALK_X_W;
  localparam int WY = mppr_pkg::WALK_Y_W;
  localparam int DW = mppr_pkg::DEC_W;
  localparam int LW = mppr_pkg::LIMIT_W;
  localparam int FW = mppr_pkg::FOCAL_W;
  localparam int SUM_W = WX + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [OUT_WIDTH-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_WIDTH-1:0];
    end else begin
      r = v[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

  logic [WY-1:0]           a2_y;      // 2a in walker y width
  logic signed [DW-1:0]    a2_d;
  logic signed [DW-1:0]    a4_d;
  logic [WY-1:0]           limit_y;
  logic [WY-1:0]           y1;
  logic                    r1_run;
  logic [WX-1:0]           x2;
  logic [WY-1:0]           y2;
  logic [WY-1:0]           y2p1;
  logic signed [DW-1:0]    d2;
  logic                    r2_run;
  logic                    have;
  logic                    more;
  mppr_pkg::walk_t         nxt;

  // constants of the current curve
  always_comb begin
    a2_y    = {1'b0, curve_i.focal, 1'b0};
    a2_d    = $signed({{(DW-FW-1){1'b0}}, curve_i.focal, 1'b0});
    a4_d    = $signed({{(DW-FW-2){1'b0}}, curve_i.focal, 2'b00});
    limit_y = {{(WY-LW){1'b0}}, curve_i.limit};
  end

  // region one candidate
  always_comb begin
    y1     = walk_i.walk_y + WY'(1);
    r1_run = !walk_i.region_two && (walk_i.walk_y < a2_y);
  end

  // region two base: either the running state or the entry point (a, 2a, -2a)
  always_comb begin
    if (walk_i.region_two) begin
      x2 = walk_i.walk_x;
      y2 = walk_i.walk_y;
      d2 = walk_i.decision;
    end else begin
      x2 = {{(WX-FW){1'b0}}, curve_i.focal};
      y2 = a2_y;
      d2 = -a2_d;
    end
    y2p1   = y2 + WY'(1);
    r2_run = (y2 < limit_y) && (x2 != mppr_pkg::WALK_X_MAX);
  end

  // next walker state
  always_comb begin
    nxt  = walk_i;
    have = 1'b0;
    if (walk_i.busy) begin
      if (r1_run) begin
        have       = 1'b1;
        nxt.walk_y = y1;
        if (walk_i.decision < 0) begin
          nxt.decision = walk_i.decision + $signed({{(DW-WY-1){1'b0}}, y1, 1'b1});
        end else begin
          nxt.walk_x   = walk_i.walk_x + WX'(1);
          nxt.decision = walk_i.decision + $signed({{(DW-WY-1){1'b0}}, y1, 1'b1})
                         - a4_d;
        end
      end else begin
        nxt.region_two = 1'b1;
        nxt.walk_x     = x2;
        nxt.walk_y     = y2;
        nxt.decision   = d2;
        if (r2_run) begin
          have       = 1'b1;
          nxt.walk_x = x2 + WX'(1);
          if (d2 > 0) begin
            nxt.decision = d2 - a4_d;
          end else begin
            nxt.walk_y   = y2p1;
            nxt.decision = d2 + $signed({{(DW-WY-1){1'b0}}, y2p1, 1'b0}) - a4_d;
          end
        end
      end
    end

    // does another pair follow this one
    if (!nxt.region_two) begin
      more = (nxt.walk_y < a2_y) || (a2_y < limit_y);
    end else begin
      more = (nxt.walk_y < limit_y) && (nxt.walk_x != mppr_pkg::WALK_X_MAX);
    end

    if (!have || !more) begin
      nxt.busy = 1'b0;
    end
  end

  assign walk_o              = nxt;
  assign flags_o.point_valid = have;
  assign flags_o.last        = !have || !more;

  // mirrored pair: x adder gets the axis the walker x runs along
  logic signed [SUM_W-1:0] base_x;
  logic signed [SUM_W-1:0] base_y;
  logic signed [SUM_W-1:0] pos_x;
  logic signed [SUM_W-1:0] pos_yp;
  logic signed [SUM_W-1:0] pos_ym;

  always_comb begin
    base_x = curve_i.vertical ? SUM_W'(centre_y_i) : SUM_W'(centre_x_i);
    base_y = curve_i.vertical ? SUM_W'(centre_x_i) : SUM_W'(centre_y_i);
    pos_x  = base_x + $signed({2'b00, nxt.walk_x});
    pos_yp = base_y + $signed({{(SUM_W-WY){1'b0}}, nxt.walk_y});
    pos_ym = base_y - $signed({{(SUM_W-WY){1'b0}}, nxt.walk_y});
  end

  always_comb begin
    first_px_o  = '0;
    first_py_o  = '0;
    second_px_o = '0;
    second_py_o = '0;
    if (have) begin
      if (curve_i.vertical) begin
        first_px_o  = sat_out(pos_yp);
        first_py_o  = sat_out(pos_x);
        second_px_o = sat_out(pos_ym);
        second_py_o = sat_out(pos_x);
      end else begin
        first_px_o  = sat_out(pos_x);
        first_py_o  = sat_out(pos_yp);
        second_px_o = sat_out(pos_x);
        second_py_o = sat_out(pos_ym);
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midpoint_parabola_raster_core. Start and step items
// go into the input stream with random gaps, and results are taken with random
// stalls. A scoreboard walks its own copy of the midpoint parabola walker for
// every accepted item and checks each result pair field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CW          = mppr_pkg::COORD_WIDTH_DEF;
  localparam int OW          = mppr_pkg::OUT_WIDTH_DEF;
  localparam int FOCAL_W     = mppr_pkg::FOCAL_W;
  localparam int LIMIT_W     = mppr_pkg::LIMIT_W;
  localparam int COLOUR_W    = mppr_pkg::COLOUR_W;
  localparam int IN_W        = ((2*CW + FOCAL_W + 1 + 2*LIMIT_W + 3*COLOUR_W + 7) / 8) * 8;
  localparam int OUT_W       = ((4*OW + 3*COLOUR_W + 7) / 8) * 8;
  localparam int FOC_LSB     = 2*CW;
  localparam int VERT_BIT    = FOC_LSB + FOCAL_W;
  localparam int XL_LSB      = VERT_BIT + 1;
  localparam int YL_LSB      = XL_LSB + LIMIT_W;
  localparam int COL_LSB     = YL_LSB + LIMIT_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_ITEMS  = 1600;

  // result item, packed to match {out_tuser, out_tlast, out_tdata}
  typedef struct packed {
    logic                point_valid;
    logic                last;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] red;
    logic [OW-1:0]       second_py;
    logic [OW-1:0]       second_px;
    logic [OW-1:0]       first_py;
    logic [OW-1:0]       first_px;
  } pair_item_t;

  // --------------------------------------------------------------------------
  // scoreboard: parabola walker copy plus the queue of pairs still due
  // --------------------------------------------------------------------------
  class pair_scoreboard;
    bit                    curve_active;
    bit                    region_two;
    bit                    vert;
    longint                walk_x;
    longint                walk_y;
    longint                decision;
    longint                cx;
    longint                cy;
    longint                focal;
    longint                limit;
    logic [3*COLOUR_W-1:0] colour;   // blue, green, red from high to low
    pair_item_t            due_pairs [$];
    int                    errors;

    function logic [OW-1:0] clamp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (OW-1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OW-1:0];
    endfunction

    // advance the walker for one accepted input item
    function void note_item(mppr_pkg::cmd_t cmd, logic [IN_W-1:0] d);
      pair_item_t p;
      bit         have;
      bit         more;
      longint     a2;
      longint     a4;
      p    = '0;
      have = 1'b0;
      more = 1'b0;
      if (cmd == mppr_pkg::CMD_START) begin
        cx           = longint'($signed(d[CW-1:0]));
        cy           = longint'($signed(d[2*CW-1:CW]));
        focal        = longint'(d[FOC_LSB +: FOCAL_W]);
        vert         = d[VERT_BIT];
        limit        = vert ? longint'(d[XL_LSB +: LIMIT_W]) : longint'(d[YL_LSB +: LIMIT_W]);
        colour       = d[COL_LSB +: 3*COLOUR_W];
        walk_x       = 0;
        walk_y       = 0;
        decision     = 1 - 2*focal;
        region_two   = 1'b0;
        curve_active = 1'b1;
        return;
      end
      if (!curve_active) begin
        p.last = 1'b1;
        due_pairs.push_back(p);
        return;
      end
      a2 = 2*focal;
      a4 = 4*focal;
      // region one: y always steps
      if (!region_two) begin
        if (walk_y < a2) begin
          walk_y++;
          if (decision < 0) begin
            decision += 1 + 2*walk_y;
          end else begin
            walk_x++;
            decision += 1 + 2*walk_y - a4;
          end
          have = 1'b1;
        end else begin
          region_two = 1'b1;
          walk_x     = focal;
          walk_y     = a2;
          decision   = -a2;
        end
      end
      // region two: x always steps, x never wraps
      if (!have && region_two && walk_y < limit &&
          walk_x < longint'(mppr_pkg::WALK_X_MAX)) begin
        walk_x++;
        if (decision > 0) begin
          decision -= a4;
        end else begin
          walk_y++;
          decision += 2*walk_y - a4;
        end
        have = 1'b1;
      end
      if (have) begin
        if (!region_two) more = (walk_y < a2) || (a2 < limit);
        else more = (walk_y < limit) && (walk_x < longint'(mppr_pkg::WALK_X_MAX));
        p.point_valid = 1'b1;
        if (vert) begin
          p.first_px  = clamp(cx + walk_y);
          p.first_py  = clamp(cy + walk_x);
          p.second_px = clamp(cx - walk_y);
          p.second_py = clamp(cy + walk_x);
        end else begin
          p.first_px  = clamp(cx + walk_x);
          p.first_py  = clamp(cy + walk_y);
          p.second_px = clamp(cx + walk_x);
          p.second_py = clamp(cy - walk_y);
        end
        {p.blue, p.green, p.red} = colour;
      end
      curve_active = more;
      p.last       = !more;
      due_pairs.push_back(p);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [OW-1:0] got, logic [OW-1:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // match one accepted result against the oldest pair due
    task check_pair(pair_item_t got);
      pair_item_t want;
      if (due_pairs.size() == 0) begin
        report($sformatf("result %h with nothing due", got));
        return;
      end
      want = due_pairs.pop_front();
      compare("point_valid", OW'(got.point_valid), OW'(want.point_valid));
      compare("last", OW'(got.last), OW'(want.last));
      compare("first_px", got.first_px, want.first_px);
      compare("first_py", got.first_py, want.first_py);
      compare("second_px", got.second_px, want.second_px);
      compare("second_py", got.second_py, want.second_py);
      compare("red_out", OW'(got.red), OW'(want.red));
      compare("green_out", OW'(got.green), OW'(want.green));
      compare("blue_out", OW'(got.blue), OW'(want.blue));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, DUT
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  pair_scoreboard board;
  int             in_gap_max    = 6;
  int             out_stall_max = 6;
  int             sent          = 0;

  initial forever #5 clk = ~clk;

  midpoint_parabola_raster_core dut (.*);

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] curve_word(int cx, int cy, int a, int vert,
                                                 int xl, int yl, int r, int g, int b);
    logic [IN_W-1:0] w;
    w                           = '0;
    w[CW-1:0]                   = cx[CW-1:0];
    w[2*CW-1:CW]                = cy[CW-1:0];
    w[FOC_LSB +: FOCAL_W]       = a[FOCAL_W-1:0];
    w[VERT_BIT]                 = vert[0];
    w[XL_LSB +: LIMIT_W]        = xl[LIMIT_W-1:0];
    w[YL_LSB +: LIMIT_W]        = yl[LIMIT_W-1:0];
    w[COL_LSB +: COLOUR_W]      = r[COLOUR_W-1:0];
    w[COL_LSB+COLOUR_W +: COLOUR_W]   = g[COLOUR_W-1:0];
    w[COL_LSB+2*COLOUR_W +: COLOUR_W] = b[COLOUR_W-1:0];
    return w;
  endfunction

  function automatic logic [IN_W-1:0] random_word();
    return curve_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
  endfunction

  // offer one item after a random gap, hold it until taken
  task automatic send_item(mppr_pkg::cmd_t cmd, logic [IN_W-1:0] word);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_item(cmd, word);
    sent++;
  endtask

  task automatic step();
    send_item(mppr_pkg::CMD_STEP, random_word());
  endtask

  // step until the curve is done or the cap is hit
  task automatic run_curve(int max_steps);
    int n;
    n = 0;
    while (board.curve_active && n < max_steps) begin
      step();
      n++;
    end
  endtask

  // hold off the sender until every due pair has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.due_pairs.size() != 0);
  endtask

  initial begin : stimulus
    int a;
    int lim;
    int vert;
    int pick;
    int rand_start;
    int left;
    board = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= mppr_pkg::CMD_STEP;
    in_tdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // step with no curve, then an empty curve
    step();
    send_item(mppr_pkg::CMD_START, curve_word(0, 0, 0, 0, 2047, 0, 1, 2, 3));
    step();
    step();
    // a = 0, vertical, extent one: a single pair at the vertex extremes
    send_item(mppr_pkg::CMD_START, curve_word(-2048, 2047, 0, 1, 1, 2047, 255, 0, 255));
    run_curve(4);
    step();
    // limit below 2a: curve ends with region one
    send_item(mppr_pkg::CMD_START, curve_word(5, -7, 1, 0, 0, 1, 0, 255, 0));
    run_curve(8);
    // both regions, horizontal
    send_item(mppr_pkg::CMD_START, curve_word(2047, -2048, 2, 0, 0, 7, 255, 255, 255));
    run_curve(20);
    // largest focal distance, left unfinished after three steps
    send_item(mppr_pkg::CMD_START, curve_word(-1, 1, 1023, 1, 2047, 2047, 0, 0, 0));
    repeat (3) step();
    drain();

    // random curves
    rand_start = sent;
    while (sent - rand_start < RAND_ITEMS) begin
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 6;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      if ($urandom_range(0, 9) == 0) drain();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        // well-formed curve, mostly small enough to finish
        a    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        lim  = (a == 0) ? $urandom_range(0, 1) : $urandom_range(0, 2*a + 40);
        vert = $urandom_range(0, 1);
        send_item(mppr_pkg::CMD_START, curve_word($urandom, $urandom, a, vert,
                                        vert ? lim : $urandom_range(0, 2047),
                                        vert ? $urandom_range(0, 2047) : lim,
                                        $urandom, $urandom, $urandom));
        if (pick < 11) begin
          left = RAND_ITEMS - (sent - rand_start);
          run_curve((left < 400) ? left : 400);
          repeat ($urandom_range(0, 2)) step();
        end else begin
          repeat ($urandom_range(0, 12)) step();
        end
      end else if (pick < 17) begin
        // arbitrary start, few steps
        send_item(mppr_pkg::CMD_START, random_word());
        repeat ($urandom_range(0, 5)) step();
      end else begin
        repeat ($urandom_range(1, 3)) step();
      end
    end

    // wait out the pairs still due, then a few more cycles
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.due_pairs.size() != 0);
    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("midpoint_parabola_raster_core test passed");
    else
      $display("midpoint_parabola_raster_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stall per item
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      board.check_pair({out_tuser, out_tlast, out_tdata});
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no item moving on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("midpoint_parabola_raster_core test failed");
        $finish;
      end
    end
  end

endmodule
